/* rtl/tpf_pkg.sv */
// ----------------------------------------------------------------------------
// tpf_pkg: shared definitions for the trapezoidal pulse filter
// Sizes, configuration register indexes, the job word that goes from the
// front end through the queue to the back end, and output saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package tpf_pkg;

  localparam int MAX_RISE      = 128;
  localparam int MAX_GAP       = 128;
  localparam int HISTORY_DEPTH = 512;
  localparam int SAMPLE_BITS   = 16;

  localparam int RISE_RESET = 5;
  localparam int GAP_RESET  = 5;

  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LEN  = CFG_IDX_W'(1);

  localparam int RISE_W = $clog2(MAX_RISE + 1);
  localparam int GAP_W  = $clog2(MAX_GAP + 1);
  localparam int SPAN_W = $clog2(2 * MAX_RISE + MAX_GAP + 1);

  // The history depth is a power of two that covers the longest span.
  localparam int HIST_AW = $clog2(HISTORY_DEPTH);

  localparam int POS_W   = 10;
  localparam int POS_MAX = (1 << POS_W) - 1;

  localparam int SUM_W  = $clog2(MAX_RISE * ((1 << SAMPLE_BITS) - 1) + 1);
  localparam int WIDE_W = SUM_W + 1;
  localparam int DIFF_W = SUM_W + 1;

  localparam int OUT_W   = 24;
  localparam int OUT_MAX = (1 << (OUT_W - 1)) - 1;
  localparam int OUT_MIN = -(1 << (OUT_W - 1));

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int QC_W    = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ITEM,
    OP_CLEAR,
    OP_ACCUM
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [SAMPLE_BITS-1:0] sample;
    logic [SAMPLE_BITS-1:0] tap_near;
    logic [SAMPLE_BITS-1:0] tap_mid;
    logic [SAMPLE_BITS-1:0] tap_far;
    logic                   trace_start;
    logic                   full;
    logic                   sub_r;
    logic                   add_l;
    logic                   to_r;
    logic                   to_l;
    logic                   gate;
  } job_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [DIFF_W-1:0] d);
    int v;
    v = int'(d);
    if (v > OUT_MAX) begin
      v = OUT_MAX;
    end else if (v < OUT_MIN) begin
      v = OUT_MIN;
    end
    return OUT_W'(v);
  endfunction

endpackage

`default_nettype wire

/* rtl/tpf_if.sv */
// ----------------------------------------------------------------------------
// tpf_if: valid/ready channels of the trapezoidal pulse filter
// tpf_in_if carries raw samples, tpf_out_if carries filter results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpf_in_if;
  logic                             valid;
  logic                             ready;
  logic [tpf_pkg::SAMPLE_BITS-1:0]  sample;
  logic                             trace_start;

  modport source (output valid, sample, trace_start, input ready);
  modport sink (input valid, sample, trace_start, output ready);
endinterface

interface tpf_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [tpf_pkg::OUT_W-1:0] filter_value;
  logic                             windows_full;

  modport source (output valid, filter_value, windows_full, input ready);
  modport sink (input valid, filter_value, windows_full, output ready);
endinterface

`default_nettype wire

/* rtl/tpf_front.sv */
// ----------------------------------------------------------------------------
// tpf_front: sample intake, history memories and job issue
// Accepts samples, tracks the trace position, writes the sample history and
// reads the three window taps. After a configuration write it issues a clear
// job and replays the history as accumulate jobs to rebuild the back end's window sums.
// ----------------------------------------------------------------------------
`default_nettype none

module tpf_front (
  input  wire                            clk,
  input  wire                            rst_n,
  tpf_in_if.sink                         in_ch,
  input  wire                            cfg_wr_en,
  input  wire [tpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [tpf_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire [tpf_pkg::QC_W-1:0]        q_count,
  output logic                           q_push,
  output tpf_pkg::job_t                  q_job
);

  logic [tpf_pkg::SAMPLE_BITS-1:0] hist_a [tpf_pkg::HISTORY_DEPTH];
  logic [tpf_pkg::SAMPLE_BITS-1:0] hist_b [tpf_pkg::HISTORY_DEPTH];

  logic [tpf_pkg::RISE_W-1:0]  rise_r, rise_nxt;
  logic [tpf_pkg::GAP_W-1:0]   gap_r, gap_nxt;
  logic [tpf_pkg::SPAN_W-1:0]  rg_r, rg_nxt;
  logic [tpf_pkg::SPAN_W-1:0]  span_r, span_nxt;
  logic [tpf_pkg::HIST_AW-1:0] wp_r, wp_nxt;
  logic [tpf_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic                        rb_active_r, rb_active_nxt;
  logic                        rb_clear_r, rb_clear_nxt;
  logic [tpf_pkg::SPAN_W-1:0]  rb_k_r, rb_k_nxt;
  logic                        s1_valid_r, s1_valid_nxt;
  tpf_pkg::job_t               s1_job_r, s1_job_nxt;
  logic [tpf_pkg::SAMPLE_BITS-1:0] rd_near_r, rd_mid_r, rd_far_r;

  logic                        can_issue;
  logic                        accept;
  logic                        rb_issue;
  logic [tpf_pkg::POS_W-1:0]   trace_pos;
  logic [tpf_pkg::HIST_AW-1:0] addr_near, addr_mid, addr_far;

  assign can_issue = ((tpf_pkg::QC_W + 1)'(q_count) + (tpf_pkg::QC_W + 1)'(s1_valid_r))
                     < tpf_pkg::Q_DEPTH;
  assign in_ch.ready = !rb_active_r && can_issue;
  assign accept      = in_ch.valid && in_ch.ready;
  assign rb_issue    = rb_active_r && can_issue;
  assign trace_pos   = in_ch.trace_start ? '0 : pos_r;

  assign addr_near = wp_r - tpf_pkg::HIST_AW'(rise_r);
  assign addr_mid  = wp_r - tpf_pkg::HIST_AW'(rg_r);
  assign addr_far  = rb_active_r ? wp_r - tpf_pkg::HIST_AW'(rb_k_r)
                                 : wp_r - tpf_pkg::HIST_AW'(span_r);

  always_comb begin
    rise_nxt = rise_r;
    gap_nxt  = gap_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        tpf_pkg::REG_RISE_LEN: begin
          if (cfg_wdata == '0) begin
            rise_nxt = tpf_pkg::RISE_W'(1);
          end else if (int'(cfg_wdata) > tpf_pkg::MAX_RISE) begin
            rise_nxt = tpf_pkg::RISE_W'(tpf_pkg::MAX_RISE);
          end else begin
            rise_nxt = tpf_pkg::RISE_W'(cfg_wdata);
          end
        end
        tpf_pkg::REG_GAP_LEN: begin
          if (int'(cfg_wdata) > tpf_pkg::MAX_GAP) begin
            gap_nxt = tpf_pkg::GAP_W'(tpf_pkg::MAX_GAP);
          end else begin
            gap_nxt = tpf_pkg::GAP_W'(cfg_wdata);
          end
        end
        default: begin
        end
      endcase
    end
    rg_nxt   = tpf_pkg::SPAN_W'(rise_nxt) + tpf_pkg::SPAN_W'(gap_nxt);
    span_nxt = rg_nxt + tpf_pkg::SPAN_W'(rise_nxt);
  end

  always_comb begin
    rb_active_nxt = rb_active_r;
    rb_clear_nxt  = rb_clear_r;
    rb_k_nxt      = rb_k_r;
    if (rb_issue) begin
      if (rb_clear_r) begin
        rb_clear_nxt = 1'b0;
      end else begin
        rb_k_nxt = rb_k_r + tpf_pkg::SPAN_W'(1);
        if (rb_k_r == span_r) begin
          rb_active_nxt = 1'b0;
        end
      end
    end
    if (cfg_wr_en) begin
      rb_active_nxt = 1'b1;
      rb_clear_nxt  = 1'b1;
      rb_k_nxt      = tpf_pkg::SPAN_W'(1);
    end
  end

  always_comb begin
    wp_nxt  = wp_r;
    pos_nxt = pos_r;
    if (accept) begin
      wp_nxt  = wp_r + tpf_pkg::HIST_AW'(1);
      pos_nxt = (int'(trace_pos) == tpf_pkg::POS_MAX) ? trace_pos
                                                      : trace_pos + tpf_pkg::POS_W'(1);
    end
  end

  always_comb begin
    s1_valid_nxt           = accept || rb_issue;
    s1_job_nxt             = '0;
    s1_job_nxt.sample      = in_ch.sample;
    s1_job_nxt.trace_start = in_ch.trace_start;
    s1_job_nxt.full        = trace_pos >= tpf_pkg::POS_W'(span_r);
    s1_job_nxt.sub_r       = trace_pos >= tpf_pkg::POS_W'(rise_r);
    s1_job_nxt.add_l       = trace_pos >= tpf_pkg::POS_W'(rg_r);
    s1_job_nxt.to_r        = rb_k_r <= tpf_pkg::SPAN_W'(rise_r);
    s1_job_nxt.to_l        = rb_k_r > rg_r;
    s1_job_nxt.gate        = tpf_pkg::POS_W'(rb_k_r) <= pos_r;
    if (rb_issue) begin
      s1_job_nxt.op = rb_clear_r ? tpf_pkg::OP_CLEAR : tpf_pkg::OP_ACCUM;
    end else begin
      s1_job_nxt.op = tpf_pkg::OP_ITEM;
    end
  end

  always_comb begin
    q_push         = s1_valid_r;
    q_job          = s1_job_r;
    q_job.tap_near = rd_near_r;
    q_job.tap_mid  = rd_mid_r;
    q_job.tap_far  = rd_far_r;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hist_a[wp_r] <= in_ch.sample;
      hist_b[wp_r] <= in_ch.sample;
    end
    rd_near_r <= hist_a[addr_near];
    rd_mid_r  <= hist_a[addr_mid];
    rd_far_r  <= hist_b[addr_far];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r      <= tpf_pkg::RISE_W'(tpf_pkg::RISE_RESET);
      gap_r       <= tpf_pkg::GAP_W'(tpf_pkg::GAP_RESET);
      rg_r        <= tpf_pkg::SPAN_W'(tpf_pkg::RISE_RESET + tpf_pkg::GAP_RESET);
      span_r      <= tpf_pkg::SPAN_W'(2 * tpf_pkg::RISE_RESET + tpf_pkg::GAP_RESET);
      wp_r        <= '0;
      pos_r       <= '0;
      rb_active_r <= 1'b0;
      rb_clear_r  <= 1'b0;
      rb_k_r      <= '0;
      s1_valid_r  <= 1'b0;
    end else begin
      rise_r      <= rise_nxt;
      gap_r       <= gap_nxt;
      rg_r        <= rg_nxt;
      span_r      <= span_nxt;
      wp_r        <= wp_nxt;
      pos_r       <= pos_nxt;
      rb_active_r <= rb_active_nxt;
      rb_clear_r  <= rb_clear_nxt;
      rb_k_r      <= rb_k_nxt;
      s1_valid_r  <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_job_r <= s1_job_nxt;
  end

`ifndef NO_ASSERTIONS
  a_no_intake_during_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    rb_active_r |-> !in_ch.ready)
    else $error("sample intake open during sum rebuild");

  a_position_advances: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_ch.trace_start && (int'(pos_r) != tpf_pkg::POS_MAX)
    |=> pos_r == $past(pos_r) + tpf_pkg::POS_W'(1))
    else $error("trace position did not advance");
`endif

endmodule

`default_nettype wire

/* rtl/tpf_queue.sv */
// ----------------------------------------------------------------------------
// tpf_queue: job queue between front end and back end
// A small first-in first-out buffer of job words with an occupancy count
// that the front end uses for flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module tpf_queue (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       push,
  input  tpf_pkg::job_t             push_job,
  input  wire                       pop,
  output tpf_pkg::job_t             head_job,
  output logic [tpf_pkg::QC_W-1:0]  count
);

  tpf_pkg::job_t                 slots [tpf_pkg::Q_DEPTH];
  logic [tpf_pkg::Q_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [tpf_pkg::Q_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [tpf_pkg::QC_W-1:0]      count_r, count_nxt;

  assign head_job = slots[rd_ptr_r];
  assign count    = count_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + tpf_pkg::Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + tpf_pkg::Q_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + tpf_pkg::QC_W'(push) - tpf_pkg::QC_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> int'(count_r) < tpf_pkg::Q_DEPTH)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("job queue underflow");
`endif

endmodule

`default_nettype wire

/* rtl/tpf_back.sv */
// ----------------------------------------------------------------------------
// tpf_back: window sums and result register
// Keeps the running right and left window sums, forms the filter value for
// each sample job and holds it in the output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tpf_back (
  input  wire                       clk,
  input  wire                       rst_n,
  input  tpf_pkg::job_t             head_job,
  input  wire [tpf_pkg::QC_W-1:0]   q_count,
  output logic                      q_pop,
  tpf_out_if.source                 out_ch
);

  logic [tpf_pkg::SUM_W-1:0]        rsum_r, rsum_nxt;
  logic [tpf_pkg::SUM_W-1:0]        lsum_r, lsum_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic signed [tpf_pkg::OUT_W-1:0] out_value_r, out_value_nxt;
  logic                             out_full_r, out_full_nxt;

  logic                             out_free;
  logic                             item_pop;
  logic [tpf_pkg::SUM_W-1:0]        base_r, base_l;
  logic [tpf_pkg::WIDE_W-1:0]       r_wide, l_wide;
  logic signed [tpf_pkg::DIFF_W-1:0] diff;

  assign out_free = !out_valid_r || out_ch.ready;
  assign q_pop    = (q_count != '0) && ((head_job.op != tpf_pkg::OP_ITEM) || out_free);
  assign item_pop = q_pop && (head_job.op == tpf_pkg::OP_ITEM);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.filter_value = out_value_r;
  assign out_ch.windows_full = out_full_r;

  always_comb begin
    base_r   = head_job.trace_start ? '0 : rsum_r;
    base_l   = head_job.trace_start ? '0 : lsum_r;
    diff     = $signed({1'b0, base_r}) - $signed({1'b0, base_l});
    rsum_nxt = rsum_r;
    lsum_nxt = lsum_r;
    r_wide   = '0;
    l_wide   = '0;
    if (q_pop) begin
      unique case (head_job.op)
        tpf_pkg::OP_ITEM: begin
          r_wide = tpf_pkg::WIDE_W'(base_r) + tpf_pkg::WIDE_W'(head_job.sample)
                 - (head_job.sub_r ? tpf_pkg::WIDE_W'(head_job.tap_near) : '0);
          l_wide = tpf_pkg::WIDE_W'(base_l)
                 + (head_job.add_l ? tpf_pkg::WIDE_W'(head_job.tap_mid) : '0)
                 - (head_job.full ? tpf_pkg::WIDE_W'(head_job.tap_far) : '0);
          rsum_nxt = tpf_pkg::SUM_W'(r_wide);
          lsum_nxt = tpf_pkg::SUM_W'(l_wide);
        end
        tpf_pkg::OP_CLEAR: begin
          rsum_nxt = '0;
          lsum_nxt = '0;
        end
        tpf_pkg::OP_ACCUM: begin
          r_wide = tpf_pkg::WIDE_W'(rsum_r)
                 + ((head_job.gate && head_job.to_r) ? tpf_pkg::WIDE_W'(head_job.tap_far) : '0);
          l_wide = tpf_pkg::WIDE_W'(lsum_r)
                 + ((head_job.gate && head_job.to_l) ? tpf_pkg::WIDE_W'(head_job.tap_far) : '0);
          rsum_nxt = tpf_pkg::SUM_W'(r_wide);
          lsum_nxt = tpf_pkg::SUM_W'(l_wide);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_full_nxt  = out_full_r;
    if (item_pop) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = head_job.full ? tpf_pkg::sat_out(diff) : '0;
      out_full_nxt  = head_job.full;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsum_r      <= '0;
      lsum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rsum_r      <= rsum_nxt;
      lsum_r      <= lsum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_full_r  <= out_full_nxt;
  end

`ifndef NO_ASSERTIONS
  a_zero_until_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_full_r |-> out_value_r == '0)
    else $error("nonzero filter value before windows are full");
`endif

endmodule

`default_nettype wire

/* rtl/trapezoidal_pulse_filter_core.sv */
// ----------------------------------------------------------------------------
// trapezoidal_pulse_filter_core: streaming trapezoidal shaping filter
// Each sample yields the right window sum minus the left window sum.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on in_ch (valid/ready); trace_start marks the first sample of
// a trace. Every accepted item gives one result on out_ch: filter_value and
// windows_full, which is 1 once 2*rise_len+gap_len samples of the trace have
// gone by. Results leave in order.
// Throughput is one item per cycle while out_ch.ready is high and no rebuild
// runs; the window sums are running sums, updated once per item from three
// history taps on two sample memories, one serving two taps and one the third.
// When out_ch.ready is low the output register holds its result and the
// four-entry job queue fills; in_ch.ready falls once the queue and the tap
// read stage hold four jobs.
// rise_len and gap_len are written on the cfg_ port; the user must do so only
// while the block is idle, as the block does not enforce it. Each write starts
// a rebuild of the window sums from the history, with in_ch.ready low meanwhile.
// Reset sets rise_len and gap_len to 5, clears the sums and trace position,
// and empties the queue and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoidal_pulse_filter_core (
  input  wire                            clk,
  input  wire                            rst_n,
  tpf_in_if.sink                         in_ch,
  tpf_out_if.source                      out_ch,
  input  wire                            cfg_wr_en,
  input  wire [tpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [tpf_pkg::CFG_W-1:0]       cfg_wdata
);

  logic                      q_push;
  logic                      q_pop;
  tpf_pkg::job_t             q_job;
  tpf_pkg::job_t             q_head;
  logic [tpf_pkg::QC_W-1:0]  q_count;

  tpf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_count   (q_count),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  tpf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head_job (q_head),
    .count    (q_count)
  );

  tpf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (q_head),
    .q_count  (q_count),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for trapezoidal_pulse_filter_core
// Sends a short table of hand-built samples and then random traces under
// several window settings. The settings include zero, oversized and maximum
// lengths, and one trace is held past the position limit. Both channels idle at
// random. Every result is checked against a bit-true shaping predictor or a typed table value.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {
    PACE_RECV_SLOW,
    PACE_SEND_SLOW,
    PACE_FULL
  } pace_t;

  typedef struct packed {
    logic signed [tpf_pkg::OUT_W-1:0] value;
    logic                             full;
  } filter_result_t;

  typedef struct packed {
    logic [tpf_pkg::SAMPLE_BITS-1:0]  sample;
    logic                             start;
    logic                             typed;
    logic signed [tpf_pkg::OUT_W-1:0] value;
    logic                             full;
  } vector_t;

  typedef struct packed {
    logic [tpf_pkg::CFG_W-1:0] rise;
    logic [tpf_pkg::CFG_W-1:0] gap;
    logic                      rand_cfg;
    logic                      long_trace;
    logic [15:0]               items;
    pace_t                     pace;
  } segment_t;

  localparam vector_t DIRECTED [28] = '{
    '{16'h0000, 1'b1, 1'b1, 24'sd0, 1'b0},
    '{16'h0000, 1'b0, 1'b1, 24'sd0, 1'b0},
    '{16'h0000, 1'b0, 1'b1, 24'sd0, 1'b0},
    '{16'h0000, 1'b0, 1'b1, 24'sd0, 1'b0},
    '{16'h0000, 1'b0, 1'b1, 24'sd0, 1'b0},
    '{16'h0000, 1'b0, 1'b1, 24'sd0, 1'b0},
    '{16'h8001, 1'b0, 1'b1, 24'sd0, 1'b0},
    '{16'h7ffe, 1'b0, 1'b1, 24'sd0, 1'b0},
    '{16'h00ff, 1'b0, 1'b1, 24'sd0, 1'b0},
    '{16'hff00, 1'b0, 1'b1, 24'sd0, 1'b0},
    '{16'hffff, 1'b0, 1'b1, 24'sd0, 1'b0},
    '{16'hffff, 1'b0, 1'b1, 24'sd0, 1'b0},
    '{16'hffff, 1'b0, 1'b1, 24'sd0, 1'b0},
    '{16'hffff, 1'b0, 1'b1, 24'sd0, 1'b0},
    '{16'hffff, 1'b0, 1'b1, 24'sd0, 1'b0},
    '{16'hffff, 1'b0, 1'b1, 24'sd327675, 1'b1},
    '{16'h0000, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'h0000, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'h0000, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'h0000, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'h0000, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'h0000, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'h0000, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'h0000, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'h0000, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'h0000, 1'b0, 1'b0, 24'sd0, 1'b0},
    '{16'h0000, 1'b0, 1'b1, -24'sd327675, 1'b1},
    '{16'hffff, 1'b1, 1'b1, 24'sd0, 1'b0}
  };

  localparam segment_t SEGMENTS [8] = '{
    '{8'd1,   8'd0,   1'b0, 1'b0, 16'd16,  PACE_RECV_SLOW},
    '{8'd0,   8'd7,   1'b0, 1'b0, 16'd16,  PACE_RECV_SLOW},
    '{8'd3,   8'd2,   1'b0, 1'b0, 16'd16,  PACE_RECV_SLOW},
    '{8'd0,   8'd0,   1'b1, 1'b0, 16'd16,  PACE_SEND_SLOW},
    '{8'd128, 8'd128, 1'b0, 1'b1, 16'd266, PACE_SEND_SLOW},
    '{8'd255, 8'd200, 1'b0, 1'b1, 16'd256, PACE_SEND_SLOW},
    '{8'd128, 8'd0,   1'b0, 1'b1, 16'd252, PACE_FULL},
    '{8'd1,   8'd128, 1'b0, 1'b1, 16'd252, PACE_FULL}
  };

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_wr_en;
  logic [tpf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tpf_pkg::CFG_W-1:0]     cfg_wdata;

  tpf_in_if  in_if();
  tpf_out_if out_if();

  trapezoidal_pulse_filter_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [tpf_pkg::SAMPLE_BITS-1:0] shaper_history [tpf_pkg::HISTORY_DEPTH];
  logic [tpf_pkg::HIST_AW-1:0]     shaper_wr_ptr;
  logic [tpf_pkg::POS_W-1:0]       shaper_position;
  logic [tpf_pkg::CFG_W-1:0]       shaper_rise;
  logic [tpf_pkg::CFG_W-1:0]       shaper_gap;

  filter_result_t pending_results [$];
  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count  = 0;
  int results_checked = 0;
  int items_sent      = 0;
  int reg_writes      = 0;
  int cycle_count     = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int effective_rise();
    int r;
    r = int'(shaper_rise);
    if (r < 1) begin
      r = 1;
    end else if (r > tpf_pkg::MAX_RISE) begin
      r = tpf_pkg::MAX_RISE;
    end
    return r;
  endfunction

  function automatic int effective_gap();
    int g;
    g = int'(shaper_gap);
    if (g > tpf_pkg::MAX_GAP) begin
      g = tpf_pkg::MAX_GAP;
    end
    return g;
  endfunction

  function automatic filter_result_t predict_filter(
      input logic [tpf_pkg::SAMPLE_BITS-1:0] smp, input logic st);
    int r;
    int g;
    int span;
    int right_sum;
    int left_sum;
    int diff;
    filter_result_t res;
    r = effective_rise();
    g = effective_gap();
    span = 2 * r + g;
    right_sum = 0;
    left_sum = 0;
    if (st) begin
      shaper_position = '0;
    end
    res.full = (int'(shaper_position) >= span);
    res.value = '0;
    if (res.full) begin
      for (int k = 1; k <= r; k++) begin
        right_sum += int'(shaper_history[shaper_wr_ptr - tpf_pkg::HIST_AW'(k)]);
      end
      for (int k = r + g + 1; k <= span; k++) begin
        left_sum += int'(shaper_history[shaper_wr_ptr - tpf_pkg::HIST_AW'(k)]);
      end
      diff = right_sum - left_sum;
      if (diff > tpf_pkg::OUT_MAX) begin
        diff = tpf_pkg::OUT_MAX;
      end else if (diff < tpf_pkg::OUT_MIN) begin
        diff = tpf_pkg::OUT_MIN;
      end
      res.value = tpf_pkg::OUT_W'(diff);
    end
    shaper_history[shaper_wr_ptr] = smp;
    shaper_wr_ptr = shaper_wr_ptr + tpf_pkg::HIST_AW'(1);
    if (shaper_position != tpf_pkg::POS_W'(tpf_pkg::POS_MAX)) begin
      shaper_position = shaper_position + tpf_pkg::POS_W'(1);
    end
    return res;
  endfunction

  function automatic void set_pace(input pace_t pace);
    case (pace)
      PACE_RECV_SLOW: begin
        send_idle_pct = 19;
        recv_idle_pct = 58;
      end
      PACE_SEND_SLOW: begin
        send_idle_pct = 58;
        recv_idle_pct = 19;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endfunction

  task automatic push_sample(input vector_t v);
    filter_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.sample      <= v.sample;
    in_if.trace_start <= v.start;
    @(posedge clk);
    while (!in_if.ready) begin
      @(posedge clk);
    end
    predicted = predict_filter(v.sample, v.start);
    if (v.typed) begin
      pending_results.insert(pending_results.size(), filter_result_t'{v.value, v.full});
    end else begin
      pending_results.insert(pending_results.size(), predicted);
    end
    items_sent++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [tpf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tpf_pkg::CFG_W-1:0] val);
    drain_results();
    while (!in_if.ready) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == tpf_pkg::REG_RISE_LEN) begin
      shaper_rise = val;
    end else begin
      shaper_gap = val;
    end
    reg_writes++;
  endtask

  initial begin
    filter_result_t want;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          $error("unexpected result: filter_value %0d, windows_full %0b",
                 $signed(out_if.filter_value), out_if.windows_full);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_if.filter_value !== want.value) begin
            $error("filter_value: expected %0d, actual %0d",
                   $signed(want.value), $signed(out_if.filter_value));
            mismatch_count++;
          end
          if (out_if.windows_full !== want.full) begin
            $error("windows_full: expected %0b, actual %0b", want.full, out_if.windows_full);
            mismatch_count++;
          end
        end
      end
      out_if.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("trapezoidal_pulse_filter_core verification failed");
    $finish;
  end

  initial begin
    vector_t  v;
    segment_t seg;
    logic [tpf_pkg::CFG_W-1:0] rise;
    logic [tpf_pkg::CFG_W-1:0] gap;
    int  trace_left;
    int  span;
    logic in_long_trace;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.sample      <= '0;
    in_if.trace_start <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= '0;
    cfg_wdata         <= '0;
    for (int i = 0; i < tpf_pkg::HISTORY_DEPTH; i++) begin
      shaper_history[i] = '0;
    end
    shaper_wr_ptr   = '0;
    shaper_position = '0;
    shaper_rise     = tpf_pkg::CFG_W'(tpf_pkg::RISE_RESET);
    shaper_gap      = tpf_pkg::CFG_W'(tpf_pkg::GAP_RESET);
    in_long_trace   = 1'b0;
    set_pace(PACE_RECV_SLOW);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      push_sample(DIRECTED[i]);
    end

    foreach (SEGMENTS[s]) begin
      seg = SEGMENTS[s];
      set_pace(seg.pace);
      if (seg.rand_cfg) begin
        rise = tpf_pkg::CFG_W'($urandom_range(1, 8));
        gap  = tpf_pkg::CFG_W'($urandom_range(0, 8));
      end else begin
        rise = seg.rise;
        gap  = seg.gap;
      end
      write_reg(tpf_pkg::REG_RISE_LEN, rise);
      write_reg(tpf_pkg::REG_GAP_LEN, gap);
      span = 2 * effective_rise() + effective_gap();
      trace_left = 0;
      for (int i = 0; i < int'(seg.items); i++) begin
        if (i == int'(seg.items) / 2) begin
          drain_results();
        end
        v.typed = 1'b0;
        v.value = '0;
        v.full  = 1'b0;
        case ($urandom_range(9))
          0: v.sample = '0;
          1: v.sample = '1;
          default: v.sample = tpf_pkg::SAMPLE_BITS'($urandom);
        endcase
        if (seg.long_trace) begin
          v.start = !in_long_trace;
          in_long_trace = 1'b1;
        end else begin
          in_long_trace = 1'b0;
          if (trace_left == 0) begin
            v.start = 1'b1;
            trace_left = $urandom_range(span / 2 + 1, 3 * span + 12);
          end else begin
            v.start = ($urandom_range(99) < 2);
          end
          trace_left--;
        end
        push_sample(v);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items through %0d register writes, including a trace held past",
             items_sent, reg_writes);
    $display("the position limit; %0d results checked, %0d mismatches.",
             results_checked, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("trapezoidal_pulse_filter_core verification clean");
    end else begin
      $display("trapezoidal_pulse_filter_core verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/tpf_pkg.sv
rtl/tpf_if.sv
rtl/tpf_front.sv
rtl/tpf_queue.sv
rtl/tpf_back.sv
rtl/trapezoidal_pulse_filter_core.sv
sim/tb_top.sv
